@@ src/twls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package twls_pkg;

   localparam int VAL_W  = 32;
   localparam int WS_W   = 9;
   localparam int XS_W   = 24;
   localparam int CSR_DW = 24;
   localparam int CSR_IW = 1;
   localparam int QUO_W  = 33;
   localparam int FRAC_W = 16;
   localparam int DIV_CW = 6;

   localparam logic [CSR_IW-1:0] CSR_WINDOW_START = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_X_STEP       = 1'd1;

   localparam logic [XS_W-1:0] X_STEP_RESET = 24'd65536;

   localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [QUO_W-1:0] NEG_LIM = 33'h0_8000_0000;
   localparam logic [QUO_W-1:0] POS_LIM = 33'h0_7FFF_FFFF;

   // product sequence for the closing computation
   localparam logic [2:0] OP_N_SKK = 3'd0;
   localparam logic [2:0] OP_SK_SK = 3'd1;
   localparam logic [2:0] OP_DEN_X = 3'd2;
   localparam logic [2:0] OP_N_SKY = 3'd3;
   localparam logic [2:0] OP_SK_SY = 3'd4;

   typedef struct packed {
      logic signed [VAL_W-1:0] sample_value;
      logic                    sample_missing;
      logic                    series_last;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] slope_value;
      logic                    slope_valid;
   } rsp_type;

   typedef struct packed {
      logic       accum;
      logic       mul_load;
      logic       mul_step;
      logic [2:0] op;
      logic       store;
      logic       div_load;
      logic       div_step;
      logic       out_load;
      logic       out_ok;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic den_ok;
      logic div_ovf;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

@@ src/twls_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module twls_datapath import twls_pkg::*; #(
   parameter int MAX_SAMPLES = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire req_type           req_payload,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_payload
);

   localparam int NW   = $clog2(MAX_SAMPLES + 1);
   localparam int KW   = $clog2(MAX_SAMPLES);
   localparam int SKW  = 2 * KW;
   localparam int SKKW = 3 * KW;
   localparam int SYW  = VAL_W + NW;
   localparam int SKYW = VAL_W + KW + NW + 1;
   localparam int PSW  = (NW > WS_W) ? NW : WS_W;
   localparam int DW1  = NW + SKKW + XS_W;
   localparam int DW2  = NW + SKYW;
   localparam int DW3  = SKW + SYW;
   localparam int PM12 = (DW1 > DW2) ? DW1 : DW2;
   localparam int PM   = (PM12 > DW3) ? PM12 : DW3;
   localparam int PW   = PM + 2;
   localparam int BW01 = (NW > SKW) ? NW : SKW;
   localparam int BW   = (BW01 > XS_W) ? BW01 : XS_W;
   localparam int SHW  = QUO_W - FRAC_W;
   localparam logic [NW-1:0] POS_MAX = NW'(MAX_SAMPLES);

   logic [WS_W-1:0]         ws_ff;
   logic [XS_W-1:0]         xs_ff;
   logic [NW-1:0]           pos_ff;
   logic [NW-1:0]           cnt_ff;
   logic [SKW-1:0]          sk_ff;
   logic [SKKW-1:0]         skk_ff;
   logic signed [SYW-1:0]   sy_ff;
   logic signed [SKYW-1:0]  sky_ff;
   logic signed [PW-1:0]    mca_ff;
   logic [BW-1:0]           mpl_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    tmp_ff;
   logic signed [PW-1:0]    den_ff;
   logic [PW-1:0]           dvs_ff;
   logic signed [PW-1:0]    num_ff;
   logic [PW-1:0]           rem_ff;
   logic [QUO_W-1:0]        bits_ff;
   logic [QUO_W-1:0]        quo_ff;
   logic [DIV_CW-1:0]       dcnt_ff;
   logic                    neg_ff;
   logic                    ovf_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [PSW-1:0]          pos_ext;
   logic [PSW-1:0]          ws_ext;
   logic [PSW-1:0]          k_full;
   logic [KW-1:0]           k;
   logic [2*KW-1:0]         kk;
   logic signed [KW+VAL_W:0] ky;
   logic                    in_win;
   logic signed [PW-1:0]    mul_a;
   logic [BW-1:0]           mul_b;
   logic [PW-1:0]           mag;
   logic [PW-1:0]           rem0;
   logic [PW:0]             r2;
   logic                    ge;
   logic [VAL_W-1:0]        sat_val;

   // sample index inside the window
   always_comb begin
      pos_ext = PSW'(pos_ff);
      ws_ext  = PSW'(ws_ff);
      in_win  = !req_payload.sample_missing && (pos_ext >= ws_ext);
      k_full  = pos_ext - ws_ext;
      k       = k_full[KW-1:0];
      kk      = (2*KW)'(k) * (2*KW)'(k);
      ky      = $signed({1'b0, k}) * req_payload.sample_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= '0;
         xs_ff <= X_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_START: ws_ff <= csr_wdata[WS_W-1:0];
            CSR_X_STEP:       xs_ff <= csr_wdata[XS_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff <= '0;
         cnt_ff <= '0;
         sk_ff  <= '0;
         skk_ff <= '0;
         sy_ff  <= '0;
         sky_ff <= '0;
      end else if (cmd.accum && (pos_ff < POS_MAX)) begin
         if (in_win) begin
            cnt_ff <= cnt_ff + 1'b1;
            sk_ff  <= sk_ff + SKW'(k);
            skk_ff <= skk_ff + SKKW'(kk);
            sy_ff  <= sy_ff + SYW'(req_payload.sample_value);
            sky_ff <= sky_ff + SKYW'(ky);
         end
         pos_ff <= pos_ff + 1'b1;
      end
   end

   // operand select for the shift-add multiplier
   always_comb begin
      case (cmd.op)
         OP_N_SKK: begin
            mul_a = PW'(skk_ff);
            mul_b = BW'(cnt_ff);
         end
         OP_SK_SK: begin
            mul_a = PW'(sk_ff);
            mul_b = BW'(sk_ff);
         end
         OP_DEN_X: begin
            mul_a = den_ff;
            mul_b = BW'(xs_ff);
         end
         OP_N_SKY: begin
            mul_a = PW'(sky_ff);
            mul_b = BW'(cnt_ff);
         end
         OP_SK_SY: begin
            mul_a = PW'(sy_ff);
            mul_b = BW'(sk_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mca_ff  <= mul_a;
         mpl_ff  <= mul_b;
         prod_ff <= '0;
      end else if (cmd.mul_step && (mpl_ff != '0)) begin
         if (mpl_ff[0]) begin
            prod_ff <= prod_ff + mca_ff;
         end
         mca_ff <= mca_ff <<< 1;
         mpl_ff <= mpl_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.op)
            OP_N_SKK: tmp_ff <= prod_ff;
            OP_SK_SK: den_ff <= tmp_ff - prod_ff;
            OP_DEN_X: dvs_ff <= $unsigned(prod_ff);
            OP_N_SKY: tmp_ff <= prod_ff;
            OP_SK_SY: num_ff <= tmp_ff - prod_ff;
            default:  ;
         endcase
      end
   end

   // restoring division of |num| * 2^16 by den * x_step
   always_comb begin
      mag  = num_ff[PW-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
      rem0 = mag >> SHW;
      r2   = {rem_ff, bits_ff[QUO_W-1]};
      ge   = r2 >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_load) begin
         rem_ff  <= rem0;
         bits_ff <= {mag[SHW-1:0], {FRAC_W{1'b0}}};
         quo_ff  <= '0;
         dcnt_ff <= DIV_CW'(QUO_W);
         neg_ff  <= num_ff[PW-1];
         ovf_ff  <= rem0 >= dvs_ff;
      end else if (cmd.div_step && (dcnt_ff != '0)) begin
         rem_ff  <= ge ? PW'(r2 - {1'b0, dvs_ff}) : PW'(r2);
         bits_ff <= bits_ff << 1;
         quo_ff  <= {quo_ff[QUO_W-2:0], ge};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_comb begin
      if (!cmd.out_ok) begin
         sat_val = '0;
      end else if (neg_ff) begin
         sat_val = (ovf_ff || (quo_ff > NEG_LIM)) ? SAT_NEG : -quo_ff[VAL_W-1:0];
      end else begin
         sat_val = (ovf_ff || (quo_ff > POS_LIM)) ? SAT_POS : quo_ff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.slope_value <= $signed(sat_val);
         rsp_ff.slope_valid <= cmd.out_ok;
      end
   end

   always_comb begin
      sts.mul_done = mpl_ff == '0;
      sts.den_ok   = !den_ff[PW-1] && (den_ff != '0) && (xs_ff != '0);
      sts.div_ovf  = ovf_ff;
      sts.div_done = dcnt_ff == '0;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result not presented after load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.slope_valid) |-> (rsp_ff.slope_value == '0))
      else $error("invalid slope carries nonzero value");

   a_accum_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accum |-> !(cmd.mul_load || cmd.div_step || cmd.clear))
      else $error("accumulate during closing computation");

endmodule
`default_nettype wire

@@ src/twls_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module twls_ctrl import twls_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_last,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DLOAD = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       ok_ff, ok_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ok_in    = ok_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      cmd.out_ok = ok_ff;
      req_stall = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            cmd.accum = req_valid;
            if (req_valid && req_last) begin
               state_in = S_LOAD;
               op_in    = OP_N_SKK;
               ok_in    = 1'b0;
            end
         end
         S_LOAD: begin
            // degenerate denominator or zero step ends early
            if ((op_ff == OP_DEN_X) && !sts.den_ok) begin
               state_in = S_DONE;
            end else begin
               cmd.mul_load = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_done) begin
               cmd.store = 1'b1;
               if (op_ff == OP_SK_SY) begin
                  state_in = S_DLOAD;
               end else begin
                  op_in    = op_ff + 3'd1;
                  state_in = S_LOAD;
               end
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            ok_in        = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done || sts.div_ovf) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_N_SKK;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ok_ff    <= ok_in;
      end
   end

endmodule
`default_nettype wire

@@ src/tail_window_least_squares_slope_top.sv @@
// one request accepted per cycle while a series accumulates; after the series_last
// request: five shift-add products, each stepping through the multiplier operand's bits
// (count up to 10 bits, sum k up to 17, x_step up to 24), one divider load, the divider
// steps and one output load, stopping after two products when the denominator or x_step
// is degenerate; output waits while rsp_stall holds a result; requests stall meanwhile
// synchronous active-high reset clears sums, position, output valid and window start and sets x_step to 65536
`timescale 1ns / 1ps
`default_nettype none
module tail_window_least_squares_slope_top import twls_pkg::*; #(
   parameter int MAX_SAMPLES = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_payload,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   twls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.series_last),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   twls_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ tb/tb_slope_checker.sv @@
`timescale 1ns / 1ps
module tb_slope_checker import twls_pkg::*; #(
   parameter int MAX_SAMPLES = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire req_type           req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rsp_type           rsp_payload,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     slope_count
);

   logic [WS_W-1:0] start_reg;
   logic [XS_W-1:0] step_reg;
   int unsigned     pos_cnt;
   longint          n_used, acc_k, acc_kk, acc_y, acc_ky;
   rsp_type         slope_queue[$];

   function automatic rsp_type predict_slope();
      rsp_type r;
      longint den, num;
      longint unsigned mag, d, q1, rem, q;
      r = '0;
      if (n_used < 2 || step_reg == 0) return r;
      den = n_used * acc_kk - acc_k * acc_k;
      if (den <= 0) return r;
      num = n_used * acc_ky - acc_k * acc_y;
      mag = (num < 0) ? 64'd0 - longint'(num) : num;
      d = longint'(den) * longint'({40'd0, step_reg});
      q1 = mag / d;
      rem = mag % d;
      if (q1 >= (64'd1 << 16)) q = 64'd1 << 32;
      else begin
         q = q1;
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
               rem = rem - d;
               q = q | 64'd1;
            end
         end
      end
      if (num < 0) begin
         if (q > (64'd1 << 31)) q = 64'd1 << 31;
         r.slope_value = 32'(64'd0 - q);
      end else begin
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         r.slope_value = 32'(q);
      end
      r.slope_valid = 1'b1;
      return r;
   endfunction

   assign pending_count = slope_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      longint  k, y;
      if (reset) begin
         start_reg <= '0;
         step_reg <= X_STEP_RESET;
         pos_cnt = 0;
         n_used = 0; acc_k = 0; acc_kk = 0; acc_y = 0; acc_ky = 0;
         slope_queue.delete();
         fail_count <= 0;
         slope_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_WINDOW_START) start_reg <= csr_wdata[WS_W-1:0];
            else if (csr_index == CSR_X_STEP) step_reg <= csr_wdata[XS_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            slope_count <= slope_count + 1;
            if (slope_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected slope result %h", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = slope_queue.pop_front();
               if (want.slope_value !== rsp_payload.slope_value ||
                   want.slope_valid !== rsp_payload.slope_valid) begin
                  if (fail_count < 10)
                     $display("slope mismatch: expected %h/%b got %h/%b",
                              want.slope_value, want.slope_valid,
                              rsp_payload.slope_value, rsp_payload.slope_valid);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (pos_cnt < MAX_SAMPLES) begin
               if (!req_payload.sample_missing && pos_cnt >= start_reg) begin
                  k = pos_cnt - start_reg;
                  y = req_payload.sample_value;
                  n_used++;
                  acc_k += k;
                  acc_kk += k * k;
                  acc_y += y;
                  acc_ky += k * y;
               end
               pos_cnt++;
            end
            if (req_payload.series_last) begin
               slope_queue.push_back(predict_slope());
               pos_cnt = 0;
               n_used = 0; acc_k = 0; acc_kk = 0; acc_y = 0; acc_ky = 0;
            end
         end
      end
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top import twls_pkg::*;;

   logic              clock, reset;
   logic              req_valid, req_stall;
   req_type           req_payload;
   logic              rsp_valid, rsp_stall;
   rsp_type           rsp_payload;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;
   int                fail_count, pending_count, slope_count;
   int                cycle_count;
   int                series_sent;
   bit                hold_rsp;

   tail_window_least_squares_slope_top DUT (.*);

   tb_slope_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 2000000) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
         if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic [31:0] val, input bit miss, input bit last,
                              input bit gaps);
      int gap;
      if (gaps && $urandom_range(0, 3) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload.sample_value <= val;
      req_payload.sample_missing <= miss;
      req_payload.series_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (last) series_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_price(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'h0064_0000 + $urandom_range(0, 32'h0004_0000);
         default: return {{12{1'b0}}, 20'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      endcase
   endfunction

   task automatic send_series(input int len, input int mode);
      for (int i = 0; i < len; i++)
         send_sample(rand_price(mode), $urandom_range(0, 9) == 0, i == len - 1, 1);
   endtask

   initial begin
      int len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_WINDOW_START;
      csr_wdata = '0;
      hold_rsp = 1'b0;
      series_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: lone sample, two extremes, missing last, rising and falling ramps
      send_sample(32'h7FFF_FFFF, 0, 1, 0);
      send_sample(32'h8000_0000, 0, 0, 0);
      send_sample(32'h7FFF_FFFF, 0, 1, 0);
      send_sample(32'h7FFF_FFFF, 0, 0, 0);
      send_sample(32'h8000_0000, 0, 0, 0);
      send_sample(32'h0, 1, 1, 0);
      send_sample(32'h0001_0000, 0, 0, 0);
      send_sample(32'h0003_0000, 0, 0, 0);
      send_sample(32'hFFFF_FFFF, 1, 0, 0);
      send_sample(32'h0007_0000, 0, 1, 0);
      drain();
      write_reg(CSR_X_STEP, 24'd1);
      send_sample(32'h8000_0000, 0, 0, 0);
      send_sample(32'h7FFF_FFFF, 0, 1, 0);
      send_sample(32'h7FFF_FFFF, 0, 0, 0);
      send_sample(32'h8000_0000, 0, 1, 0);
      drain();
      write_reg(CSR_X_STEP, 24'd0);
      send_sample(32'h0001_0000, 0, 0, 0);
      send_sample(32'h0005_0000, 0, 1, 0);
      drain();
      write_reg(CSR_X_STEP, 24'hFF_FFFF);
      write_reg(CSR_WINDOW_START, CSR_DW'(2));
      for (int i = 0; i < 5; i++) send_sample(32'h0010_0000 * i, 0, i == 4, 0);
      drain();
      // long series, window starting near its end
      write_reg(CSR_WINDOW_START, CSR_DW'(190));
      write_reg(CSR_X_STEP, 24'd65536);
      for (int i = 0; i < 200; i++) send_sample($urandom, 0, i == 199, 0);
      drain();

      // long receiver hold-off while requests keep coming
      write_reg(CSR_WINDOW_START, CSR_DW'(0));
      hold_rsp = 1'b1;
      for (int s = 0; s < 8; s++) send_series($urandom_range(2, 4), 1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_reg(CSR_WINDOW_START, CSR_DW'($urandom_range(0, 6)));
         case (phase)
            0: write_reg(CSR_X_STEP, 24'd65536);
            1: write_reg(CSR_X_STEP, CSR_DW'($urandom_range(1, 24'hFF_FFFF)));
            2: write_reg(CSR_X_STEP, CSR_DW'($urandom_range(1, 300)));
            default: write_reg(CSR_X_STEP, 24'd32768);
         endcase
         for (int s = 0; s < 6; s++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) + 1 : $urandom_range(2, 10);
            send_series(len, $urandom_range(0, 2));
         end
         drain();
      end

      $display("summary: %0d series sent, %0d slope results checked", series_sent, slope_count);
      $display("covered zero, unit and full x_step, late window start, missing samples,");
      $display("saturation and a long receiver hold-off");
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/twls_pkg.sv
src/twls_datapath.sv
src/twls_ctrl.sv
src/tail_window_least_squares_slope_top.sv
tb/tb_slope_checker.sv
tb/tb_top.sv
